/* hdl/cgf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cgf_pkg;

  localparam int FracBitsDef = 16;
  localparam int DivSteps    = 96;  // quotient bits of G*ma*mb / clamped d2
  localparam int SqrtSteps   = 34;  // root bits of the exact d2
  localparam int CmpSteps    = 32;  // quotient bits of each force component

  typedef enum logic [1:0] {
    REG_GRAV    = 2'd0,
    REG_MIN_DSQ = 2'd1,
    REG_MAX_DSQ = 2'd2
  } reg_idx_t;

  // differences, magnitudes and first product
  typedef struct packed {
    logic        vld;
    logic        negx;
    logic        negy;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [63:0] gm;
    logic [31:0] mb;
  } s1_t;

  typedef struct packed {
    logic        vld;
    logic        negx;
    logic        negy;
    logic        zero;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [65:0] sx;
    logic [65:0] sy;
    logic [63:0] plo;
    logic [63:0] phi;
  } s2_t;

  typedef struct packed {
    logic        vld;
    logic        negx;
    logic        negy;
    logic        zero;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [65:0] d2;
    logic [95:0] num;
  } s3_t;

  // magnitude divider and square root run side by side
  typedef struct packed {
    logic        vld;
    logic        negx;
    logic        negy;
    logic        zero;
    logic        satd;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [63:0] c;
    logic [63:0] rem;
    logic [95:0] num;
    logic [95:0] q;
    logic [67:0] rad;
    logic [35:0] srem;
    logic [33:0] root;
  } dv_t;

  typedef struct packed {
    logic        vld;
    logic        negx;
    logic        negy;
    logic        zero;
    logic        satd;
    logic [33:0] len;
    logic [64:0] mx0;
    logic [64:0] mx1;
    logic [64:0] mx2;
    logic [64:0] my0;
    logic [64:0] my1;
    logic [64:0] my2;
    logic [65:0] tx;
    logic [65:0] ty;
  } e_t;

  typedef struct packed {
    logic         vld;
    logic         negx;
    logic         negy;
    logic         zero;
    logic         satd;
    logic [33:0]  len;
    logic [127:0] px;
    logic [127:0] py;
    logic [65:0]  tx;
    logic [65:0]  ty;
  } f_t;

  // component dividers
  typedef struct packed {
    logic        vld;
    logic        negx;
    logic        negy;
    logic        zero;
    logic        satd;
    logic        satx;
    logic        saty;
    logic [33:0] len;
    logic [31:0] nx;
    logic [33:0] rx;
    logic [31:0] qx;
    logic [31:0] ny;
    logic [33:0] ry;
    logic [31:0] qy;
  } cp_t;

endpackage
`default_nettype wire

/* hdl/clamped_gravity_force_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Gravity force on body a toward body b, fixed point.
// Input channel in_*: one item = a pair of bodies, positions and masses.
// Output channel out_*: force_x, force_y in out_tdata, saturation flag in out_tuser.
// Config: cfg_we/cfg_addr/cfg_wdata write grav_const (0), min_dist_sq (1),
// max_dist_sq (2); other addresses are ignored. Write only while idle.
// Throughput: one item per cycle while the output is not stalled. The magnitude
// divider takes 96 one-bit steps and the component dividers 32, plus 8
// arithmetic stages. The square root runs alongside the first 34 divider steps.
// Stall: the whole pipeline holds while out_tvalid is high and out_tready low;
// in_tready drops in the same cycle, nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits and loads the
// config defaults: G = 1.0, min_dist_sq = 1.0, max_dist_sq = all ones.
module clamped_gravity_force_core #(
  parameter int FRAC_BITS = cgf_pkg::FracBitsDef
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // a_pos_x, a_pos_y, b_pos_x, b_pos_y, mass_a, mass_b
  input  wire  [191:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // force_x, force_y
  output logic [63:0]  out_tdata,
  // saturated
  output logic [0:0]   out_tuser,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [63:0]  cfg_wdata
);

  localparam int DS = cgf_pkg::DivSteps;
  localparam int SS = cgf_pkg::SqrtSteps;
  localparam int CS = cgf_pkg::CmpSteps;

  logic [31:0] grav_r;
  logic [63:0] min_dsq_r;
  logic [63:0] max_dsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r    <= 32'd1 << FRAC_BITS;
      min_dsq_r <= 64'd1 << (2 * FRAC_BITS);
      max_dsq_r <= '1;
    end else if (cfg_we) begin
      unique case (cgf_pkg::reg_idx_t'(cfg_addr))
        cgf_pkg::REG_GRAV:    grav_r    <= cfg_wdata[31:0];
        cgf_pkg::REG_MIN_DSQ: min_dsq_r <= cfg_wdata;
        cgf_pkg::REG_MAX_DSQ: max_dsq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_tvalid_r;
  logic [63:0] out_tdata_r;
  logic        out_sat_r;

  assign en         = !out_tvalid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_sat_r;

  // stage 1
  cgf_pkg::s1_t s1_r, s1_nxt;
  logic signed [32:0] dx, dy;

  always_comb begin
    dx = {in_tdata[95], in_tdata[95:64]} - {in_tdata[31], in_tdata[31:0]};
    dy = {in_tdata[127], in_tdata[127:96]} - {in_tdata[63], in_tdata[63:32]};
    s1_nxt.vld  = in_tvalid;
    s1_nxt.negx = dx[32];
    s1_nxt.negy = dy[32];
    s1_nxt.ax   = dx[32] ? 33'(-dx) : 33'(dx);
    s1_nxt.ay   = dy[32] ? 33'(-dy) : 33'(dy);
    s1_nxt.gm   = 64'(grav_r) * 64'(in_tdata[159:128]);
    s1_nxt.mb   = in_tdata[191:160];
  end

  // stage 2
  cgf_pkg::s2_t s2_r, s2_nxt;
  always_comb begin
    s2_nxt.vld  = s1_r.vld;
    s2_nxt.negx = s1_r.negx;
    s2_nxt.negy = s1_r.negy;
    s2_nxt.zero = (s1_r.ax == '0) && (s1_r.ay == '0);
    s2_nxt.ax   = s1_r.ax;
    s2_nxt.ay   = s1_r.ay;
    s2_nxt.sx   = 66'(s1_r.ax) * 66'(s1_r.ax);
    s2_nxt.sy   = 66'(s1_r.ay) * 66'(s1_r.ay);
    s2_nxt.plo  = 64'(s1_r.gm[31:0]) * 64'(s1_r.mb);
    s2_nxt.phi  = 64'(s1_r.gm[63:32]) * 64'(s1_r.mb);
  end

  // stage 3
  cgf_pkg::s3_t s3_r, s3_nxt;
  always_comb begin
    s3_nxt.vld  = s2_r.vld;
    s3_nxt.negx = s2_r.negx;
    s3_nxt.negy = s2_r.negy;
    s3_nxt.zero = s2_r.zero;
    s3_nxt.ax   = s2_r.ax;
    s3_nxt.ay   = s2_r.ay;
    s3_nxt.d2   = s2_r.sx + s2_r.sy;
    s3_nxt.num  = 96'(s2_r.plo) + {s2_r.phi, 32'h0};
  end

  // stage 4: saturate and clamp d2, load dividers
  cgf_pkg::dv_t dv_r [DS+1];
  cgf_pkg::dv_t dv0_nxt;
  logic [63:0] d2s, lo_c;
  always_comb begin
    dv0_nxt.vld  = s3_r.vld;
    dv0_nxt.negx = s3_r.negx;
    dv0_nxt.negy = s3_r.negy;
    dv0_nxt.zero = s3_r.zero;
    dv0_nxt.satd = |s3_r.d2[65:64];
    d2s  = dv0_nxt.satd ? '1 : s3_r.d2[63:0];
    lo_c = (d2s < min_dsq_r) ? min_dsq_r : d2s;
    dv0_nxt.c    = (lo_c > max_dsq_r) ? max_dsq_r : lo_c;
    dv0_nxt.ax   = s3_r.ax;
    dv0_nxt.ay   = s3_r.ay;
    dv0_nxt.rem  = '0;
    dv0_nxt.num  = s3_r.num;
    dv0_nxt.q    = '0;
    dv0_nxt.rad  = {2'b00, s3_r.d2};
    dv0_nxt.srem = '0;
    dv0_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld     <= 1'b0;
      s2_r.vld     <= 1'b0;
      s3_r.vld     <= 1'b0;
      dv_r[0].vld  <= 1'b0;
    end else if (en) begin
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      s3_r    <= s3_nxt;
      dv_r[0] <= dv0_nxt;
    end
  end

  // restoring divider, one quotient bit per stage; root bits in the first stages
  for (genvar i = 0; i < DS; i++) begin : g_div
    cgf_pkg::dv_t nxt;
    logic [64:0] t;
    logic        ge;
    logic [37:0] st;
    logic [37:0] trial;
    logic        sge;

    always_comb begin
      nxt   = dv_r[i];
      t     = {dv_r[i].rem, dv_r[i].num[95]};
      ge    = t >= {1'b0, dv_r[i].c};
      nxt.rem = ge ? 64'(t - {1'b0, dv_r[i].c}) : t[63:0];
      nxt.q   = {dv_r[i].q[94:0], ge};
      nxt.num = {dv_r[i].num[94:0], 1'b0};
      st    = {dv_r[i].srem, dv_r[i].rad[67:66]};
      trial = {2'b00, dv_r[i].root, 2'b01};
      sge   = st >= trial;
      if (i < SS) begin
        nxt.srem = sge ? 36'(st - trial) : st[35:0];
        nxt.root = {dv_r[i].root[32:0], sge};
        nxt.rad  = {dv_r[i].rad[65:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1].vld <= 1'b0;
      end else if (en) begin
        dv_r[i+1] <= nxt;
      end
    end
  end

  // stage E: magnitude times |dx| and |dy| in 32-bit slices, saturation thresholds
  cgf_pkg::e_t e_r, e_nxt;
  cgf_pkg::dv_t dl;
  always_comb begin
    dl = dv_r[DS];
    e_nxt.vld  = dl.vld;
    e_nxt.negx = dl.negx;
    e_nxt.negy = dl.negy;
    e_nxt.zero = dl.zero;
    e_nxt.satd = dl.satd;
    e_nxt.len  = dl.root;
    e_nxt.mx0  = 65'(dl.q[31:0])  * 65'(dl.ax);
    e_nxt.mx1  = 65'(dl.q[63:32]) * 65'(dl.ax);
    e_nxt.mx2  = 65'(dl.q[95:64]) * 65'(dl.ax);
    e_nxt.my0  = 65'(dl.q[31:0])  * 65'(dl.ay);
    e_nxt.my1  = 65'(dl.q[63:32]) * 65'(dl.ay);
    e_nxt.my2  = 65'(dl.q[95:64]) * 65'(dl.ay);
    // quotient reaches the limit + 1 exactly when p >= (limit + 1) * len
    e_nxt.tx   = (66'(dl.root) << 31) + (dl.negx ? 66'(dl.root) : 66'd0);
    e_nxt.ty   = (66'(dl.root) << 31) + (dl.negy ? 66'(dl.root) : 66'd0);
  end

  // stage F
  cgf_pkg::f_t f_r, f_nxt;
  always_comb begin
    f_nxt.vld  = e_r.vld;
    f_nxt.negx = e_r.negx;
    f_nxt.negy = e_r.negy;
    f_nxt.zero = e_r.zero;
    f_nxt.satd = e_r.satd;
    f_nxt.len  = e_r.len;
    f_nxt.tx   = e_r.tx;
    f_nxt.ty   = e_r.ty;
    f_nxt.px   = 128'(e_r.mx0) + (128'(e_r.mx1) << 32) + (128'(e_r.mx2) << 64);
    f_nxt.py   = 128'(e_r.my0) + (128'(e_r.my1) << 32) + (128'(e_r.my2) << 64);
  end

  // stage G: saturation test, load component dividers
  cgf_pkg::cp_t cp_r [CS+1];
  cgf_pkg::cp_t cp0_nxt;
  always_comb begin
    cp0_nxt.vld  = f_r.vld;
    cp0_nxt.negx = f_r.negx;
    cp0_nxt.negy = f_r.negy;
    cp0_nxt.zero = f_r.zero;
    cp0_nxt.satd = f_r.satd;
    cp0_nxt.satx = f_r.px >= 128'(f_r.tx);
    cp0_nxt.saty = f_r.py >= 128'(f_r.ty);
    cp0_nxt.len  = f_r.len;
    // without saturation p >> 32 is already below len
    cp0_nxt.nx   = f_r.px[31:0];
    cp0_nxt.rx   = f_r.px[65:32];
    cp0_nxt.qx   = '0;
    cp0_nxt.ny   = f_r.py[31:0];
    cp0_nxt.ry   = f_r.py[65:32];
    cp0_nxt.qy   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.vld     <= 1'b0;
      f_r.vld     <= 1'b0;
      cp_r[0].vld <= 1'b0;
    end else if (en) begin
      e_r     <= e_nxt;
      f_r     <= f_nxt;
      cp_r[0] <= cp0_nxt;
    end
  end

  for (genvar j = 0; j < CS; j++) begin : g_cmp
    cgf_pkg::cp_t nxt;
    logic [34:0] tx, ty;
    logic        gx, gy;

    always_comb begin
      nxt    = cp_r[j];
      tx     = {cp_r[j].rx, cp_r[j].nx[31]};
      ty     = {cp_r[j].ry, cp_r[j].ny[31]};
      gx     = tx >= {1'b0, cp_r[j].len};
      gy     = ty >= {1'b0, cp_r[j].len};
      nxt.rx = gx ? 34'(tx - {1'b0, cp_r[j].len}) : tx[33:0];
      nxt.ry = gy ? 34'(ty - {1'b0, cp_r[j].len}) : ty[33:0];
      nxt.qx = {cp_r[j].qx[30:0], gx};
      nxt.qy = {cp_r[j].qy[30:0], gy};
      nxt.nx = {cp_r[j].nx[30:0], 1'b0};
      nxt.ny = {cp_r[j].ny[30:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cp_r[j+1].vld <= 1'b0;
      end else if (en) begin
        cp_r[j+1] <= nxt;
      end
    end
  end

  // output stage: limits, sign, zero separation
  cgf_pkg::cp_t cl;
  logic [31:0] fx, fy;
  logic        fsat;
  always_comb begin
    cl = cp_r[CS];
    if (cl.satx) fx = cl.negx ? 32'h8000_0000 : 32'h7fff_ffff;
    else         fx = cl.negx ? 32'(-cl.qx) : cl.qx;
    if (cl.saty) fy = cl.negy ? 32'h8000_0000 : 32'h7fff_ffff;
    else         fy = cl.negy ? 32'(-cl.qy) : cl.qy;
    fsat = cl.satd || cl.satx || cl.saty;
    if (cl.zero) begin
      fx   = '0;
      fy   = '0;
      fsat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= cl.vld;
      out_tdata_r  <= {fy, fx};
      out_sat_r    <= fsat;
    end
  end

  // a stalled output freezes the whole pipe
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      ($stable(s1_r.vld) && $stable(dv_r[DS].vld) && $stable(cp_r[CS].vld)))
    else $error("pipeline advanced during output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !dv_r[0].vld && !cp_r[0].vld))
    else $error("valid bits survive reset");

endmodule
`default_nettype wire
